/* rtl/dmspc_pkg.sv */
// Shared constants and codes for the DC motor speed PI controller.
`timescale 1ns / 1ps

package dmspc_pkg;

    // Default sizes of the edge counter and the integral accumulator
    localparam int COUNT_BITS_DEF = 10;
    localparam int ACC_BITS_DEF   = 16;

    // Stream payload widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 40;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P          = 2'd0,
        REG_GAIN_I          = 2'd1,
        REG_GAIN_D          = 2'd2,
        REG_SETPOINT_OFFSET = 2'd3
    } cfg_reg_t;

    // Item kinds carried in s_tuser
    typedef enum logic {
        MODE_HALL = 1'b0,
        MODE_TICK = 1'b1
    } mode_t;

    // Register reset values
    localparam logic [3:0] GAIN_P_RESET  = 4'd1;
    localparam logic [3:0] GAIN_I_RESET  = 4'd1;
    localparam logic [3:0] GAIN_D_RESET  = 4'd0;
    localparam logic [7:0] OFFSET_RESET  = 8'd73;

    // Speed scale 354/100 kept as quotient and remainder: each edge adds
    // 3 to the quotient and 54 to the remainder, with a carry at 100.
    localparam int SPEED_Q_STEP = 3;
    localparam int SPEED_R_STEP = 54;
    localparam int SPEED_DEN    = 100;
    localparam int REM_W        = 7;

    // Joystick divide by 7 as multiply by 2341 / 2^14 (exact for 10-bit input)
    localparam int STICK_RECIP = 2341;
    localparam int STICK_SHIFT = 14;
    localparam int STICK_PROD_W = 22;

    // Output field widths
    localparam int SPEED_FB_W = 13;
    localparam int DRIVE_W    = 16;
    localparam int DUTY_W     = 8;

endpackage

/* rtl/dc_motor_speed_pi_controller.sv */
// DC motor speed PI(D) controller: hall edge counting, direction filter, PID step.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_*): s_tuser[0] is the item kind, hall edge or control tick.
//   A hall edge counts one edge (saturating) and shifts the inverted hall level
//   into a three-deep direction history. A control tick resolves direction,
//   scales the edge count by 3.54 into a signed speed, takes the setpoint as
//   joystick/7 minus an offset, runs one PID step and clears the edge count.
//   Only ticks produce a result transaction on the output stream (m_*).
//   Configuration (cfg_*): gains and setpoint offset, written by index; always
//   ready. Write only while no item is in flight.
//   A tick passes from the input register to the result register (m_tvalid).
//   Throughput: one transaction per cycle unless stalled; the input and result
//   registers each hold one item, and the PID math is a single registered pass.
//   The edge count is scaled incrementally (quotient and remainder) as edges
//   arrive, so a tick needs no multiply on the count.
//   Stall: while a result waits on m_tready, hall edges still flow through; a
//   tick held in the input register blocks s_tready until the result is taken.
//   Reset (aresetn low, synchronous): registers to their defaults, edge count
//   zero, direction forward, integral and last error zero, both stages empty.
module dc_motor_speed_pi_controller #(
    parameter int COUNT_BITS = dmspc_pkg::COUNT_BITS_DEF,
    parameter int ACC_BITS   = dmspc_pkg::ACC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dmspc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dmspc_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dmspc_pkg::S_TDATA_W-1:0]   s_tdata,  // [0] hall_level, [10:1] stick_sample
    input  logic [dmspc_pkg::S_TUSER_W-1:0]   s_tuser,  // [0] mode
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dmspc_pkg::M_TDATA_W-1:0]   m_tdata   // [0] reverse, [8:1] duty,
                                                        // [24:9] drive_value,
                                                        // [37:25] speed_feedback
);
    import dmspc_pkg::*;

    localparam int Q_W    = COUNT_BITS + 2;
    localparam int SPD_W  = (COUNT_BITS + 3 > 17) ? COUNT_BITS + 3 : 17;
    localparam int ERR_W  = SPD_W + 1;
    localparam int IS_W   = ((ACC_BITS > 21) ? ACC_BITS : 21) + 1;
    localparam int DRV_W  = ((ACC_BITS > 22) ? ACC_BITS : 22) + 2;

    // Configuration registers
    logic [3:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [7:0] offset_reg;

    // Input stage
    logic       in_valid_reg;
    mode_t      in_mode_reg;
    logic       in_hall_reg;
    logic [7:0] in_stick7_reg;

    // Controller state
    logic [COUNT_BITS-1:0]      count_reg, count_next;
    logic [Q_W-1:0]             spd_q_reg, spd_q_next;
    logic [REM_W-1:0]           spd_r_reg, spd_r_next;
    logic [2:0]                 hist_reg, hist_next;
    logic                       fwd_reg, fwd_next;
    logic signed [ACC_BITS-1:0] integ_reg, integ_next;
    logic signed [DRIVE_W-1:0]  last_err_reg, last_err_next;

    // Result stage
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic advance, is_tick, out_load;
    logic [STICK_PROD_W-1:0] stick_prod;
    logic [REM_W:0]          rem_sum;
    logic                    fwd_tick;
    logic signed [SPD_W-1:0] speed;
    logic signed [8:0]       setpoint;
    logic signed [ERR_W-1:0] err_wide;
    logic signed [DRIVE_W-1:0] err;
    logic signed [20:0]      p_term, i_term;
    logic signed [DRIVE_W:0] err_diff;
    logic signed [21:0]      d_term;
    logic signed [IS_W-1:0]  integ_sum;
    logic signed [DRV_W-1:0] drive_sum;
    logic signed [DRIVE_W-1:0] drive;
    logic [DRIVE_W:0]        mag;
    logic [DUTY_W-1:0]       duty;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign is_tick   = (in_mode_reg == MODE_TICK);
    assign advance   = in_valid_reg && (!is_tick || !out_valid_reg || m_tready);
    assign out_load  = advance && is_tick;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Divide the joystick sample by 7 on the way into the input register
    assign stick_prod = STICK_PROD_W'(s_tdata[10:1]) * STICK_PROD_W'(STICK_RECIP);

    // Advance the scaled count by 354/100 per edge
    assign rem_sum = (REM_W + 1)'(spd_r_reg) + (REM_W + 1)'(SPEED_R_STEP);

    // Resolve direction: change only when all three samples agree
    always_comb begin
        fwd_tick = fwd_reg;
        if (hist_reg == 3'b111) begin
            fwd_tick = 1'b1;
        end else if (hist_reg == 3'b000) begin
            fwd_tick = 1'b0;
        end
    end

    // Signed speed, setpoint and error clamped to 16 bits
    always_comb begin
        speed = $signed({{(SPD_W - Q_W){1'b0}}, spd_q_reg});
        if (!fwd_tick) begin
            speed = -speed;
        end
        setpoint = $signed({1'b0, in_stick7_reg}) - $signed({1'b0, offset_reg});
        err_wide = ERR_W'(setpoint) - ERR_W'(speed);
        if (err_wide[ERR_W-1:DRIVE_W-1] == {(ERR_W - DRIVE_W + 1){err_wide[DRIVE_W-1]}}) begin
            err = err_wide[DRIVE_W-1:0];
        end else begin
            err = err_wide[ERR_W-1] ? {1'b1, {(DRIVE_W - 1){1'b0}}}
                                    : {1'b0, {(DRIVE_W - 1){1'b1}}};
        end
    end

    // PID terms
    assign p_term   = 21'(err) * 21'($signed({1'b0, gain_p_reg}));
    assign i_term   = 21'(err) * 21'($signed({1'b0, gain_i_reg}));
    assign err_diff = (DRIVE_W + 1)'(err) - (DRIVE_W + 1)'(last_err_reg);
    assign d_term   = 22'(err_diff) * 22'($signed({1'b0, gain_d_reg}));
    assign integ_sum = IS_W'(integ_reg) + IS_W'(i_term);

    // Saturate the integral at the accumulator range
    always_comb begin
        if (integ_sum[IS_W-1:ACC_BITS-1] == {(IS_W - ACC_BITS + 1){integ_sum[ACC_BITS-1]}}) begin
            integ_next = integ_sum[ACC_BITS-1:0];
        end else begin
            integ_next = integ_sum[IS_W-1] ? {1'b1, {(ACC_BITS - 1){1'b0}}}
                                           : {1'b0, {(ACC_BITS - 1){1'b1}}};
        end
    end

    // Drive value, saturated to 16 bits, and its magnitude
    assign drive_sum = DRV_W'(p_term) + DRV_W'(integ_next) + DRV_W'(d_term);

    always_comb begin
        if (drive_sum[DRV_W-1:DRIVE_W-1] == {(DRV_W - DRIVE_W + 1){drive_sum[DRIVE_W-1]}}) begin
            drive = drive_sum[DRIVE_W-1:0];
        end else begin
            drive = drive_sum[DRV_W-1] ? {1'b1, {(DRIVE_W - 1){1'b0}}}
                                       : {1'b0, {(DRIVE_W - 1){1'b1}}};
        end
        mag = drive[DRIVE_W-1] ? -{drive[DRIVE_W-1], drive} : {1'b0, drive};
        duty = (|mag[DRIVE_W:DUTY_W]) ? {DUTY_W{1'b1}} : mag[DUTY_W-1:0];
    end

    // State update for the item leaving the input register
    always_comb begin
        count_next     = count_reg;
        spd_q_next     = spd_q_reg;
        spd_r_next     = spd_r_reg;
        hist_next      = hist_reg;
        fwd_next       = fwd_reg;
        last_err_next  = last_err_reg;
        if (advance) begin
            if (is_tick) begin
                fwd_next      = fwd_tick;
                last_err_next = err;
                count_next    = '0;
                spd_q_next    = '0;
                spd_r_next    = '0;
            end else begin
                hist_next = {hist_reg[1:0], ~in_hall_reg};
                if (count_reg != {COUNT_BITS{1'b1}}) begin
                    count_next = count_reg + COUNT_BITS'(1);
                    if (rem_sum >= (REM_W + 1)'(SPEED_DEN)) begin
                        spd_r_next = REM_W'(rem_sum - (REM_W + 1)'(SPEED_DEN));
                        spd_q_next = spd_q_reg + Q_W'(SPEED_Q_STEP + 1);
                    end else begin
                        spd_r_next = REM_W'(rem_sum);
                        spd_q_next = spd_q_reg + Q_W'(SPEED_Q_STEP);
                    end
                end
            end
        end
    end

    // Result register: load on a tick, drop when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg    <= GAIN_P_RESET;
            gain_i_reg    <= GAIN_I_RESET;
            gain_d_reg    <= GAIN_D_RESET;
            offset_reg    <= OFFSET_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            spd_q_reg     <= '0;
            spd_r_reg     <= '0;
            hist_reg      <= 3'b111;
            fwd_reg       <= 1'b1;
            integ_reg     <= '0;
            last_err_reg  <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_GAIN_P:          gain_p_reg <= cfg_data[3:0];
                    REG_GAIN_I:          gain_i_reg <= cfg_data[3:0];
                    REG_GAIN_D:          gain_d_reg <= cfg_data[3:0];
                    REG_SETPOINT_OFFSET: offset_reg <= cfg_data;
                    default:             ;
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            spd_q_reg     <= spd_q_next;
            spd_r_reg     <= spd_r_next;
            hist_reg      <= hist_next;
            fwd_reg       <= fwd_next;
            last_err_reg  <= last_err_next;
            if (out_load) begin
                integ_reg <= integ_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg   <= mode_t'(s_tuser[0]);
            in_hall_reg   <= s_tdata[0];
            in_stick7_reg <= stick_prod[STICK_SHIFT +: 8];
        end
        if (out_load) begin
            out_data_reg <= {2'b00,
                             speed[SPEED_FB_W-1:0],
                             drive,
                             duty,
                             drive[DRIVE_W-1]};
        end
    end

    // Checks
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        spd_r_reg < REM_W'(SPEED_DEN))
        else $error("speed remainder out of range");

    a_tick_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (count_reg == '0) && (spd_q_reg == '0) && (spd_r_reg == '0))
        else $error("edge count not cleared after a tick");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten while held");

    a_reverse_matches_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg[0] == out_data_reg[24]))
        else $error("reverse flag disagrees with drive sign");

endmodule
